// ===== sv/rpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types, codes and field widths for the reference-counted page
// allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int NUM_PAGES_DEF = 4096;

    localparam int OP_W       = 2;
    localparam int PAGE_IN_W  = 16;
    localparam int STATUS_W   = 3;
    localparam int PAGE_OUT_W = 12;
    localparam int COUNT_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INC   = 2'd2,
        OP_DEC   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_RANGE = 3'd2,
        ST_UNDER = 3'd3,
        ST_SAT   = 3'd4,
        ST_FULL  = 3'd5
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } sts_t;

endpackage

// ===== sv/rpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer: clearing pass after reset, then request load and commit.
// ----------------------------------------------------------------------------
module rpa_ctrl
    import rpa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!sts.out_blocked) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/rpa_datapath.sv =====
// ----------------------------------------------------------------------------
// rpa_datapath
// Count and free-stack memories, stack fill, result logic and output register.
// ----------------------------------------------------------------------------
module rpa_datapath
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [OP_W-1:0]       s_operation,
    input  logic [PAGE_IN_W-1:0]  s_page,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [PAGE_OUT_W-1:0] m_page_out,
    output logic [COUNT_W-1:0]    m_count,
    output logic                  m_freed
);

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam logic [PW:0]          FILL_FULL = (PW+1)'(NUM_PAGES);
    localparam logic [PW-1:0]        IDX_LAST  = PW'(NUM_PAGES - 1);
    localparam logic [PAGE_IN_W:0]   PAGE_LIM  = (PAGE_IN_W+1)'(NUM_PAGES);

    logic [COUNT_W-1:0] count_mem [NUM_PAGES];
    logic [PW-1:0]      stack_mem [NUM_PAGES];

    logic [PW-1:0]        clr_idx_reg;
    logic [PW:0]          fill_reg, fill_next;
    op_t                  op_reg;
    logic [PAGE_IN_W-1:0] page_reg;
    logic [COUNT_W-1:0]   rd_count_reg;
    logic [PW-1:0]        rd_top_reg;

    logic                  cnt_we, stk_we;
    logic [PW-1:0]         cnt_waddr, stk_waddr, stk_wdata;
    logic [COUNT_W-1:0]    cnt_wdata, cnt_less;
    logic [PW-1:0]         idx_pg;
    logic                  in_range, push_ok;

    status_t               res_status;
    logic [PAGE_OUT_W-1:0] res_page;
    logic [COUNT_W-1:0]    res_count;
    logic                  res_freed;

    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [PAGE_OUT_W-1:0] m_page_out_reg;
    logic [COUNT_W-1:0]    m_count_reg;
    logic                  m_freed_reg;

    assign idx_pg   = PW'(page_reg);
    assign in_range = {1'b0, page_reg} < PAGE_LIM;
    assign push_ok  = fill_reg != FILL_FULL;
    assign cnt_less = rd_count_reg - COUNT_ONE;

    assign sts.clear_last  = clr_idx_reg == IDX_LAST;
    assign sts.out_blocked = m_valid_reg && !m_ready;

    always_comb begin
        cnt_we     = 1'b0;
        cnt_waddr  = idx_pg;
        cnt_wdata  = '0;
        stk_we     = 1'b0;
        stk_waddr  = fill_reg[PW-1:0];
        stk_wdata  = idx_pg;
        fill_next  = fill_reg;
        res_status = ST_OK;
        res_page   = PAGE_OUT_W'(page_reg);
        res_count  = '0;
        res_freed  = 1'b0;
        if (cmd.clear) begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_idx_reg;
            stk_we    = 1'b1;
            stk_waddr = clr_idx_reg;
            stk_wdata = clr_idx_reg;
        end else if (cmd.exec) begin
            if (op_reg == OP_ALLOC) begin
                if (fill_reg == '0) begin
                    res_status = ST_EMPTY;
                    res_page   = '0;
                end else begin
                    fill_next = fill_reg - 1'b1;
                    cnt_we    = 1'b1;
                    cnt_waddr = rd_top_reg;
                    cnt_wdata = COUNT_ONE;
                    res_page  = PAGE_OUT_W'(rd_top_reg);
                    res_count = COUNT_ONE;
                end
            end else if (!in_range) begin
                res_status = ST_RANGE;
            end else begin
                case (op_reg)
                    OP_FREE: begin
                        cnt_we    = 1'b1;
                        cnt_wdata = (rd_count_reg != '0) ? cnt_less : '0;
                        res_count = cnt_wdata;
                    end
                    OP_INC: begin
                        if (rd_count_reg == COUNT_MAX) begin
                            res_status = ST_SAT;
                            res_count  = rd_count_reg;
                        end else begin
                            cnt_we    = 1'b1;
                            cnt_wdata = rd_count_reg + COUNT_ONE;
                            res_count = cnt_wdata;
                        end
                    end
                    OP_DEC: begin
                        if (rd_count_reg == '0) begin
                            res_status = ST_UNDER;
                        end else begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_less;
                            res_count = cnt_less;
                        end
                    end
                    default: begin
                        res_status = ST_OK;
                    end
                endcase
                if (cnt_we && cnt_wdata == '0) begin
                    if (push_ok) begin
                        stk_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        res_freed = 1'b1;
                    end else begin
                        res_status = ST_FULL;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.load) begin
            rd_count_reg <= count_mem[PW'(s_page)];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (cmd.load) begin
            rd_top_reg <= stack_mem[PW'(fill_reg - 1'b1)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= op_t'(s_operation);
            page_reg <= s_page;
        end
        if (cmd.exec) begin
            m_status_reg   <= res_status;
            m_page_out_reg <= res_page;
            m_count_reg    <= res_count;
            m_freed_reg    <= res_freed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            fill_reg    <= FILL_FULL;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            fill_reg <= fill_next;
            if (cmd.exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_page_out = m_page_out_reg;
    assign m_count    = m_count_reg;
    assign m_freed    = m_freed_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("free stack fill beyond page count");

    a_freed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_freed_reg |-> m_status_reg == ST_OK)
        else $error("page pushed with an error status");

    a_alloc_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && op_reg == OP_ALLOC && fill_reg != '0
        |=> fill_reg == $past(fill_reg) - 1'b1)
        else $error("allocate did not pop the free stack");

    a_no_exec_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten before transfer");
`endif

endmodule

// ===== sv/refcounted_page_allocator.sv =====
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Page frame allocator with a LIFO free stack and a reference count per page.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | s_valid s_ready s_operation s_page      | in
//  result  | m_valid m_ready m_status m_page_out     | out
//          | m_count m_freed                         |
//
//  Each request first reads the count and stack-top memories, then
//  writes them back and loads the result register.
//  After reset a clearing pass over all NUM_PAGES entries fills the memories;
//  s_ready stays low during it.
//  A new request is taken while a result waits; the commit stalls only
//  while the result register still holds an untaken transfer.
// ----------------------------------------------------------------------------
module refcounted_page_allocator
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_operation,
    input  logic [PAGE_IN_W-1:0]  s_page,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [PAGE_OUT_W-1:0] m_page_out,
    output logic [COUNT_W-1:0]    m_count,
    output logic                  m_freed
);

    cmd_t cmd;
    sts_t sts;

    rpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rpa_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_operation (s_operation),
        .s_page      (s_page),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_page_out  (m_page_out),
        .m_count     (m_count),
        .m_freed     (m_freed)
    );

endmodule
